FILE: sv/sbda_pkg.sv
// ----------------------------------------------------------------------------
// sbda_pkg
// shared constants and types for the signed binary to decimal ascii block
// ----------------------------------------------------------------------------
package sbda_pkg;

    localparam int VALUE_W     = 32;
    localparam int MAX_DIGITS  = 10;
    localparam int DIGIT_IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int BCD_W       = 4 * MAX_DIGITS;
    localparam int ITER_W      = $clog2(VALUE_W);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_MINUS = 8'd45;

    // one classified word waiting for conversion
    typedef struct packed {
        logic               negative;
        logic [VALUE_W-1:0] magnitude;
    } sbda_entry_t;

    // queue status seen by the back end
    typedef struct packed {
        logic        not_empty;
        sbda_entry_t head;
    } sbda_q_status_t;

endpackage

FILE: sv/sbda_front.sv
// ----------------------------------------------------------------------------
// sbda_front
// accepts input words, splits them into sign and unsigned magnitude
// ----------------------------------------------------------------------------
module sbda_front (
    input  logic [sbda_pkg::VALUE_W-1:0] value,
    input  logic                         item_valid,
    input  logic                         q_full,
    output logic                         item_stall,
    output logic                         push,
    output sbda_pkg::sbda_entry_t        entry
);
    import sbda_pkg::*;

    logic negative;

    assign negative        = value[VALUE_W-1];
    // unsigned negate keeps the most negative value exact
    assign entry.negative  = negative;
    assign entry.magnitude = negative ? (VALUE_W'(0) - value) : value;
    assign item_stall      = q_full;
    assign push            = item_valid & ~q_full;

endmodule

FILE: sv/sbda_queue.sv
// ----------------------------------------------------------------------------
// sbda_queue
// short queue between front and back end
// ----------------------------------------------------------------------------
module sbda_queue (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  sbda_pkg::sbda_entry_t    push_entry,
    input  logic                     pop,
    output logic                     full,
    output sbda_pkg::sbda_q_status_t status
);
    import sbda_pkg::*;

    sbda_entry_t       slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full             = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign status.not_empty = (count_reg != '0);
    assign status.head      = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

FILE: sv/sbda_back.sv
// ----------------------------------------------------------------------------
// sbda_back
// shift-and-add-3 conversion to decimal digits, then character emission
// ----------------------------------------------------------------------------
module sbda_back (
    input  logic                     clk,
    input  logic                     rst_n,
    input  sbda_pkg::sbda_q_status_t q_status,
    output logic                     pop,
    output logic                     char_valid,
    input  logic                     char_stall,
    output logic [7:0]               text_char,
    output logic                     last
);
    import sbda_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CONV   = 3'd1;
    localparam logic [2:0] ST_LEN    = 3'd2;
    localparam logic [2:0] ST_SIGN   = 3'd3;
    localparam logic [2:0] ST_DIGITS = 3'd4;

    logic [2:0]             state_reg, state_next;
    logic [VALUE_W-1:0]     mag_reg, mag_next;
    logic                   neg_reg, neg_next;
    logic [BCD_W-1:0]       bcd_reg, bcd_next;
    logic                   ovf_reg, ovf_next;
    logic [ITER_W-1:0]      iter_reg, iter_next;
    logic [DIGIT_IDX_W-1:0] idx_reg, idx_next;
    logic                   char_valid_reg, char_valid_next;
    logic [7:0]             text_char_reg, text_char_next;
    logic                   last_reg, last_next;

    logic [BCD_W-1:0]       bcd_adj;
    logic [DIGIT_IDX_W-1:0] lead_idx;
    logic [3:0]             cur_digit;
    logic                   slot_free;
    logic                   load_char;

    assign slot_free = ~char_valid_reg | ~char_stall;
    assign cur_digit = bcd_reg[4*idx_reg +: 4];

    // add 3 to every digit of 5 or more before the shift
    always_comb
    begin
        for (int i = 0; i < MAX_DIGITS; i++)
        begin
            bcd_adj[4*i +: 4] = (bcd_reg[4*i +: 4] >= 4'd5) ?
                                bcd_reg[4*i +: 4] + 4'd3 : bcd_reg[4*i +: 4];
        end
    end

    // highest nonzero digit, digit 0 when all are zero
    always_comb
    begin
        lead_idx = '0;
        for (int i = 0; i < MAX_DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] != 4'd0)
            begin
                lead_idx = DIGIT_IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        mag_next        = mag_reg;
        neg_next        = neg_reg;
        bcd_next        = bcd_reg;
        ovf_next        = ovf_reg;
        iter_next       = iter_reg;
        idx_next        = idx_reg;
        text_char_next  = text_char_reg;
        last_next       = last_reg;
        pop             = 1'b0;
        load_char       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_status.not_empty)
                begin
                    pop        = 1'b1;
                    mag_next   = q_status.head.magnitude;
                    neg_next   = q_status.head.negative;
                    bcd_next   = '0;
                    ovf_next   = 1'b0;
                    iter_next  = '0;
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                bcd_next  = {bcd_adj[BCD_W-2:0], mag_reg[VALUE_W-1]};
                // a digit shifted out above the store: every stored digit is shown
                ovf_next  = ovf_reg | bcd_adj[BCD_W-1];
                mag_next  = {mag_reg[VALUE_W-2:0], 1'b0};
                iter_next = iter_reg + 1'b1;
                if (iter_reg == ITER_W'(VALUE_W - 1))
                begin
                    state_next = ST_LEN;
                end
            end
            ST_LEN:
            begin
                idx_next   = ovf_reg ? DIGIT_IDX_W'(MAX_DIGITS - 1) : lead_idx;
                state_next = neg_reg ? ST_SIGN : ST_DIGITS;
            end
            ST_SIGN:
            begin
                if (slot_free)
                begin
                    load_char      = 1'b1;
                    text_char_next = CHAR_MINUS;
                    last_next      = 1'b0;
                    state_next     = ST_DIGITS;
                end
            end
            ST_DIGITS:
            begin
                if (slot_free)
                begin
                    load_char      = 1'b1;
                    text_char_next = CHAR_ZERO + {4'b0000, cur_digit};
                    last_next      = (idx_reg == '0);
                    if (idx_reg == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        char_valid_next = char_valid_reg;
        if (load_char)
        begin
            char_valid_next = 1'b1;
        end
        else if (!char_stall)
        begin
            char_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            char_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            char_valid_reg <= char_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg       <= mag_next;
        neg_reg       <= neg_next;
        bcd_reg       <= bcd_next;
        ovf_reg       <= ovf_next;
        iter_reg      <= iter_next;
        idx_reg       <= idx_next;
        text_char_reg <= text_char_next;
        last_reg      <= last_next;
    end

    assign char_valid = char_valid_reg;
    assign text_char  = text_char_reg;
    assign last       = last_reg;

    a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (state_reg == ST_IDLE) && q_status.not_empty)
        else $error("queue popped outside idle");

    a_conv_to_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CONV) && (iter_reg == ITER_W'(VALUE_W - 1)) |=>
        (state_reg == ST_LEN))
        else $error("conversion did not end after full shift count");

    a_len_next: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LEN) |=> (state_reg == ST_SIGN) || (state_reg == ST_DIGITS))
        else $error("length step went to wrong state");

    a_digit_char: assert property (@(posedge clk) disable iff (!rst_n)
        (load_char && (state_reg == ST_DIGITS)) |=>
        (text_char_reg >= CHAR_ZERO) && (text_char_reg <= CHAR_ZERO + 8'd9))
        else $error("digit character out of range");

endmodule

FILE: sv/signed_binary_to_decimal_ascii.sv
// first character: the word waits in the queue, the back end pops it in its idle state,
//   then runs 32 shift steps, the leading digit search and the output register load
// per number: 32-step shift-and-add-3 loop in the back end, then n = 1 to 11 characters,
//   each loaded when the output register is free; the queue takes new words until full
// reset: rst_n asynchronous active low clears queue, sequencer and output valid
// ----------------------------------------------------------------------------
// signed_binary_to_decimal_ascii
// converts a signed 32-bit word to its decimal text, one ascii character per
// output word, most significant digit first, optional leading minus sign
// ----------------------------------------------------------------------------
module signed_binary_to_decimal_ascii (
    input  logic                         clk,
    input  logic                         rst_n,
    // input channel
    input  logic [sbda_pkg::VALUE_W-1:0] value,
    input  logic                         item_valid,
    output logic                         item_stall,
    // output channel
    output logic [7:0]                   text_char,
    output logic                         last,
    output logic                         char_valid,
    input  logic                         char_stall
);
    import sbda_pkg::*;

    // front to queue
    logic           push;
    sbda_entry_t    push_entry;
    logic           q_full;

    // queue to back end
    sbda_q_status_t q_status;
    logic           pop;

    // front end: sign split and unsigned magnitude, stalls only on a full queue
    sbda_front u_front (
        .value      (value),
        .item_valid (item_valid),
        .q_full     (q_full),
        .item_stall (item_stall),
        .push       (push),
        .entry      (push_entry)
    );

    // short queue so a new word is taken while the back end still works
    sbda_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (q_full),
        .status     (q_status)
    );

    // back end: binary to bcd by shifting, then sign and digits through the
    // output register; the last flag marks the final digit of the number
    sbda_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_status   (q_status),
        .pop        (pop),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .text_char  (text_char),
        .last       (last)
    );

endmodule
